/* rtl/vpj_pkg.sv */
// Shared types, register indexes and reset constants of the velocity PID block.
package vpj_pkg;

  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
  // Width of the full sum of the three gain products before the fraction shift.
  localparam int unsigned SUM_W = 36;

  typedef logic [7:0] cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_P        = 8'd0;
  localparam cfg_idx_t REG_GAIN_I        = 8'd1;
  localparam cfg_idx_t REG_GAIN_D        = 8'd2;
  localparam cfg_idx_t REG_DRIVE_MAX     = 8'd3;
  localparam cfg_idx_t REG_DRIVE_MIN     = 8'd4;
  localparam cfg_idx_t REG_INTEG_LIMIT   = 8'd5;
  localparam cfg_idx_t REG_JAM_THRESHOLD = 8'd6;
  localparam cfg_idx_t REG_REVERSE_TICKS = 8'd7;

  localparam logic signed [15:0] DRIVE_MAX_RST     = 16'sd10000;
  localparam logic signed [15:0] DRIVE_MIN_RST     = -16'sd10000;
  localparam logic [14:0]        INTEG_LIMIT_RST   = 15'd4000;
  localparam logic [14:0]        JAM_THRESHOLD_RST = 15'd8000;
  localparam logic [7:0]         REVERSE_TICKS_RST = 8'd50;
  localparam logic [7:0]         REV_COUNT_IDLE    = 8'd255;

  typedef struct packed {
    logic signed [15:0] ref_speed;
    logic signed [15:0] meas_speed;
  } vpj_in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               reversing;
  } vpj_out_t;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [15:0] drive_max;
    logic signed [15:0] drive_min;
    logic [14:0]        integ_limit;
    logic [14:0]        jam_threshold;
    logic [7:0]         reverse_ticks;
  } vpj_cfg_t;

endpackage

/* rtl/velocity_pid_with_jam_reverse.sv */
// Top level of the velocity PID controller with jam reversal.
// A request accepted into the input register passes through the datapath to the result register
// and the output; throughput is one request per cycle while the output is not stalled.
// A result held by a stalled output still lets the input register take one more request.
// Reset: asynchronous and active low; clears integral, previous error, reversal counter
// (to idle) and both valid flags, and restores the configuration defaults.
module velocity_pid_with_jam_reverse #(
  parameter int unsigned GAIN_FRAC_BITS = vpj_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vpj_pkg::vpj_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vpj_pkg::vpj_out_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  vpj_pkg::cfg_idx_t cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import vpj_pkg::*;

  vpj_cfg_t cfg;
  vpj_in_t  in_req_q;
  logic     in_valid_q, in_valid_d;
  vpj_out_t out_rsp_q, core_rsp;
  logic     out_valid_q, out_valid_d;
  logic     advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  vpj_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vpj_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (in_req_q),
    .cfg_i     (cfg),
    .rsp_o     (core_rsp)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= core_rsp;
    end
  end

  // A new result only appears after the input register handed a request over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(advance))
    else $error("result appeared without an advancing request");

  // A waiting request is never dropped while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_req_q))
    else $error("stalled request lost from the input register");

  // Reversal saturates, so a reversed drive never shows the most negative code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.reversing |-> out_rsp_o.drive != 16'sh8000)
    else $error("reversed drive not saturated");

endmodule

/* rtl/vpj_cfg.sv */
// Configuration register file of the velocity PID block.
module vpj_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  vpj_pkg::cfg_idx_t cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output vpj_pkg::vpj_cfg_t cfg_o
);
  import vpj_pkg::*;

  vpj_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= '0;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.drive_max     <= DRIVE_MAX_RST;
      cfg_q.drive_min     <= DRIVE_MIN_RST;
      cfg_q.integ_limit   <= INTEG_LIMIT_RST;
      cfg_q.jam_threshold <= JAM_THRESHOLD_RST;
      cfg_q.reverse_ticks <= REVERSE_TICKS_RST;
    end else if (cfg_valid_i) begin
      // Indexes past the last register are dropped.
      unique case (cfg_index_i)
        REG_GAIN_P:        cfg_q.gain_p        <= cfg_data_i;
        REG_GAIN_I:        cfg_q.gain_i        <= cfg_data_i;
        REG_GAIN_D:        cfg_q.gain_d        <= cfg_data_i;
        REG_DRIVE_MAX:     cfg_q.drive_max     <= $signed(cfg_data_i);
        REG_DRIVE_MIN:     cfg_q.drive_min     <= $signed(cfg_data_i);
        REG_INTEG_LIMIT:   cfg_q.integ_limit   <= cfg_data_i[14:0];
        REG_JAM_THRESHOLD: cfg_q.jam_threshold <= cfg_data_i[14:0];
        REG_REVERSE_TICKS: cfg_q.reverse_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/vpj_core.sv */
// PID datapath with integral clamp, drive clamp, jam detection and reversal counter.
module vpj_core #(
  parameter int unsigned GAIN_FRAC_BITS = vpj_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  vpj_pkg::vpj_in_t  req_i,
  input  vpj_pkg::vpj_cfg_t cfg_i,
  output vpj_pkg::vpj_out_t rsp_o
);
  import vpj_pkg::*;

  localparam int unsigned SHW = SUM_W - GAIN_FRAC_BITS;

  logic signed [16:0] prev_err_q;
  logic signed [15:0] integ_q;
  logic [7:0]         rev_cnt_q, rev_cnt_d;

  logic signed [16:0]    err;
  logic signed [17:0]    diff, acc_raw, acc_clamp, lim_pos, lim_neg;
  logic signed [15:0]    acc;
  logic signed [16:0]    gp_s, gi_s, gd_s;
  logic signed [33:0]    p_prod;
  logic signed [32:0]    i_prod;
  logic signed [34:0]    d_prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [SHW-1:0] shifted, dmax_w, dmin_w;
  logic signed [15:0]    d16, d_neg;
  logic signed [16:0]    d17, thr_pos, thr_neg;
  logic                  jam;
  logic [7:0]            cnt_start;
  logic                  rev;

  always_comb begin
    err     = 17'(req_i.ref_speed) - 17'(req_i.meas_speed);
    diff    = 18'(err) - 18'(prev_err_q);
    acc_raw = 18'(integ_q) + 18'(err);
    lim_pos = $signed({3'b000, cfg_i.integ_limit});
    lim_neg = -lim_pos;

    priority if (acc_raw < lim_neg) begin
      acc_clamp = lim_neg;
    end else if (acc_raw > lim_pos) begin
      acc_clamp = lim_pos;
    end else begin
      acc_clamp = acc_raw;
    end
    acc = acc_clamp[15:0];

    gp_s   = $signed({1'b0, cfg_i.gain_p});
    gi_s   = $signed({1'b0, cfg_i.gain_i});
    gd_s   = $signed({1'b0, cfg_i.gain_d});
    p_prod = 34'(gp_s) * 34'(err);
    i_prod = 33'(gi_s) * 33'(acc);
    d_prod = 35'(gd_s) * 35'(diff);
    sum    = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);

    // Arithmetic shift rounds toward minus infinity.
    shifted = SHW'(sum >>> GAIN_FRAC_BITS);
    dmax_w  = SHW'(cfg_i.drive_max);
    dmin_w  = SHW'(cfg_i.drive_min);

    // The low clamp is tested first so crossed limits resolve as specified.
    priority if (shifted <= dmin_w) begin
      d16 = cfg_i.drive_min;
    end else if (shifted >= dmax_w) begin
      d16 = cfg_i.drive_max;
    end else begin
      d16 = shifted[15:0];
    end

    d17     = 17'(d16);
    thr_pos = $signed({2'b00, cfg_i.jam_threshold});
    thr_neg = -thr_pos;
    jam     = ((d17 >= thr_pos) || (d17 <= thr_neg)) && (req_i.meas_speed == 16'sd0);

    cnt_start = jam ? 8'd0 : rev_cnt_q;
    rev       = cnt_start < cfg_i.reverse_ticks;
    d_neg     = (d16 == 16'sh8000) ? 16'sh7FFF : -d16;
    rev_cnt_d = rev ? cnt_start + 8'd1 : cnt_start;

    rsp_o.drive     = rev ? d_neg : d16;
    rsp_o.reversing = rev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      rev_cnt_q  <= REV_COUNT_IDLE;
    end else if (advance_i) begin
      prev_err_q <= err;
      integ_q    <= acc;
      rev_cnt_q  <= rev_cnt_d;
    end
  end

  // A reversed tick always leaves the counter past zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && rev |=> rev_cnt_q != 8'd0)
    else $error("reversal counter zero after a reversed tick");

endmodule

/* tb/vpj_checker.sv */
// Checker that predicts each drive command of the velocity PID and compares it with the output.
module vpj_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  vpj_pkg::vpj_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  vpj_pkg::vpj_out_t out_rsp_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  vpj_pkg::cfg_idx_t cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int                errors_o,
  output int                pending_o,
  output int                checked_o,
  output int                reversed_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vpj_pkg::*;

  vpj_cfg_t           regs;
  logic signed [16:0] last_err;
  logic signed [15:0] err_sum;
  logic [7:0]         jam_cnt;
  vpj_out_t           drive_q[$];

  task automatic flag(input string msg);
    errors_o++;
    if (errors_o <= 10) $display("mismatch: %s", msg);
  endtask

  // Advances the controller state by one tick and returns the drive it commands.
  function automatic vpj_out_t control_tick(input vpj_in_t req);
    longint   err;
    longint   slope;
    longint   acc;
    longint   lim;
    longint   sum;
    longint   d;
    longint   thr;
    vpj_out_t rsp;
    err   = longint'($signed(req.ref_speed)) - longint'($signed(req.meas_speed));
    slope = err - longint'(last_err);
    lim   = longint'(regs.integ_limit);
    acc   = longint'(err_sum) + err;
    if (acc < -lim) acc = -lim;
    if (acc > lim) acc = lim;
    err_sum  = acc[15:0];
    last_err = err[16:0];

    sum = longint'(regs.gain_p) * err + longint'(regs.gain_i) * acc
        + longint'(regs.gain_d) * slope;
    d = sum >>> GAIN_FRAC_BITS_DEF;

    // The lower clamp wins when the two clamps cross.
    if (d <= longint'($signed(regs.drive_min))) d = longint'($signed(regs.drive_min));
    else if (d >= longint'($signed(regs.drive_max))) d = longint'($signed(regs.drive_max));

    thr = longint'(regs.jam_threshold);
    if ((d >= thr || d <= -thr) && req.meas_speed == 16'sd0) jam_cnt = 8'd0;

    rsp.reversing = 1'b0;
    if (jam_cnt < regs.reverse_ticks) begin
      d = -d;
      if (d > 32767) d = 32767;
      jam_cnt       = jam_cnt + 8'd1;
      rsp.reversing = 1'b1;
    end
    rsp.drive = d[15:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vpj_out_t want;
    if (!rst_ni) begin
      regs               = '0;
      regs.drive_max     = DRIVE_MAX_RST;
      regs.drive_min     = DRIVE_MIN_RST;
      regs.integ_limit   = INTEG_LIMIT_RST;
      regs.jam_threshold = JAM_THRESHOLD_RST;
      regs.reverse_ticks = REVERSE_TICKS_RST;
      last_err           = '0;
      err_sum            = '0;
      jam_cnt            = REV_COUNT_IDLE;
      drive_q.delete();
      errors_o           = 0;
      pending_o          = 0;
      checked_o          = 0;
      reversed_o         = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (drive_q.size() == 0) begin
          flag($sformatf("drive %0d reversing %0b arrived with no request outstanding",
                         out_rsp_i.drive, out_rsp_i.reversing));
        end else begin
          want = drive_q.pop_front();
          if (want.reversing) reversed_o++;
          if (out_rsp_i.drive !== want.drive || out_rsp_i.reversing !== want.reversing) begin
            flag($sformatf("result %0d: expected drive %0d reversing %0b, got %0d %0b",
                           checked_o, want.drive, want.reversing,
                           out_rsp_i.drive, out_rsp_i.reversing));
          end
        end
      end
      if (in_valid_i && in_ready_i) drive_q.push_back(control_tick(in_req_i));
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          REG_GAIN_P:        regs.gain_p        = cfg_data_i;
          REG_GAIN_I:        regs.gain_i        = cfg_data_i;
          REG_GAIN_D:        regs.gain_d        = cfg_data_i;
          REG_DRIVE_MAX:     regs.drive_max     = cfg_data_i;
          REG_DRIVE_MIN:     regs.drive_min     = cfg_data_i;
          REG_INTEG_LIMIT:   regs.integ_limit   = cfg_data_i[14:0];
          REG_JAM_THRESHOLD: regs.jam_threshold = cfg_data_i[14:0];
          REG_REVERSE_TICKS: regs.reverse_ticks = cfg_data_i[7:0];
          default: ;
        endcase
      end
      pending_o = drive_q.size();
    end
  end

endmodule

/* tb/tb_velocity_pid_with_jam_reverse.sv */
// Testbench top for the velocity PID with jam reversal: stimulus, handshakes and verdict.
module tb_velocity_pid_with_jam_reverse;
  timeunit 1ns;
  timeprecision 1ps;
  import vpj_pkg::*;

  localparam int       CYCLE_LIMIT  = 200000;
  localparam int       SEGMENTS     = 12;
  localparam int       SEG_TICKS    = 120;
  localparam int       DRAIN_CYCLES = 4;
  localparam cfg_idx_t REG_PAST_END = 8'd8;
  localparam cfg_idx_t REG_IDX_TOP  = 8'd255;

  typedef enum {SET_RANDOM, SET_FULL_SCALE, SET_ZERO} setting_kind_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  vpj_in_t     in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  vpj_out_t    out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  int errors;
  int pending;
  int checked;
  int reversed;
  int cycle_cnt    = 0;
  int settings     = 0;
  int send_idle    = 20;
  int recv_idle    = 52;
  logic signed [15:0] setpoint = '0;

  always #2 clk_i = ~clk_i;

  velocity_pid_with_jam_reverse dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  vpj_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_i   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .reversed_o  (reversed)
  );

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("tb_velocity_pid_with_jam_reverse: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic end_reg_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] dmax,
                               input logic [15:0] dmin, input logic [15:0] ilim,
                               input logic [15:0] thr, input logic [15:0] ticks);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_MAX, dmax);
    write_reg(REG_DRIVE_MIN, dmin);
    write_reg(REG_INTEG_LIMIT, ilim);
    write_reg(REG_JAM_THRESHOLD, thr);
    write_reg(REG_REVERSE_TICKS, ticks);
    end_reg_writes();
    settings++;
  endtask

  task automatic pick_setting(input setting_kind_e kind);
    logic [15:0] gain [3];
    logic [15:0] dmax;
    logic [15:0] dmin;
    logic [15:0] ilim;
    logic [15:0] thr;
    logic [15:0] ticks;
    if (kind == SET_FULL_SCALE) begin
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd32767, -16'sd32768,
                    16'd32767, 16'd32767, 16'd254);
    end else if (kind == SET_ZERO) begin
      apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
    end else begin
      foreach (gain[k]) begin
        case ($urandom_range(0, 4))
          0:       gain[k] = '0;
          1:       gain[k] = 16'hFFFF;
          2, 3:    gain[k] = 16'($urandom_range(0, 600));
          default: gain[k] = 16'($urandom);
        endcase
      end
      case ($urandom_range(0, 5))
        0: begin
          dmax = 16'sd32767;
          dmin = -16'sd32768;
        end
        1: begin
          // Crossed clamps.
          dmax = 16'(-int'($urandom_range(0, 20000)));
          dmin = 16'($urandom_range(0, 20000));
        end
        default: begin
          dmax = 16'($urandom_range(100, 20000));
          dmin = 16'(-int'($urandom_range(100, 20000)));
        end
      endcase
      case ($urandom_range(0, 3))
        0:       ilim = '0;
        1:       ilim = 16'd32767;
        2:       ilim = 16'($urandom_range(0, 32767));
        default: ilim = 16'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 3))
        0:       thr = '0;
        1:       thr = 16'd32767;
        2:       thr = 16'($urandom_range(0, 32767));
        default: thr = 16'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 5))
        0:       ticks = '0;
        1:       ticks = 16'd254;
        2:       ticks = 16'd255;
        default: ticks = 16'($urandom_range(1, 30));
      endcase
      apply_setting(gain[0], gain[1], gain[2], dmax, dmin, ilim, thr, ticks);
    end
  endtask

  task automatic send_tick(input logic signed [15:0] ref_speed,
                           input logic signed [15:0] meas_speed);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= {ref_speed, meas_speed};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A motor tracking a slowly moving setpoint, mixed with stalls, jumps and full-range noise.
  task automatic send_random_tick();
    logic signed [15:0] r;
    logic signed [15:0] m;
    if ($urandom_range(0, 19) == 0) setpoint = 16'(int'($urandom_range(0, 40000)) - 20000);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r = setpoint;
        m = ($urandom_range(0, 7) == 0) ? 16'sd0
                                        : 16'(int'(setpoint) + int'($urandom_range(0, 600)) - 300);
      end
      4: begin
        r = 16'($urandom);
        m = 16'sd0;
      end
      5, 6: begin
        r = 16'($urandom);
        m = 16'($urandom);
      end
      7: begin
        r = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        m = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'($urandom_range(0, 1) != 0 ? -1 : 0);
      end
      default: begin
        r = 16'(int'($urandom_range(0, 2000)) - 1000);
        m = 16'(int'($urandom_range(0, 100)) - 50);
      end
    endcase
    send_tick(r, m);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    setting_kind_e kind;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes, then a jam, then a second jam while the drive is still reversed.
    apply_setting(16'd256, 16'd16, 16'd64, 16'sd10000, -16'sd10000,
                  16'd4000, 16'd8000, 16'd3);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sh7FFF, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh8000);
    send_tick(16'sd9000, 16'sd0);
    send_tick(16'sd100, 16'sd5);
    send_tick(16'sd9000, 16'sd0);
    send_tick(16'sd100, 16'sd5);
    send_tick(16'sd0, 16'sd1);
    settle();

    // Reversing the most negative drive saturates; a zero threshold jams at any drive.
    apply_setting(16'hFFFF, '0, '0, 16'sd32767, -16'sd32768, 16'd4000, '0, 16'd2);
    send_tick(16'sh8000, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    settle();

    apply_setting(16'd256, '0, '0, -16'sd1000, 16'sd1000, 16'd4000, 16'd32767, '0);
    send_tick(16'sd500, 16'sd3);
    send_tick(16'sd5000, 16'sd3);
    send_tick(-16'sd5000, 16'sd3);
    settle();

    // A reversal length of 255 keeps the counter at work for 255 ticks.
    apply_setting(16'd256, 16'd8, 16'd32, 16'sd10000, -16'sd10000, 16'd4000, '0, 16'd255);
    send_tick(16'sd100, 16'sd0);
    send_tick(16'sd100, 16'sd7);
    send_tick(-16'sd50, 16'sd7);
    settle();

    // Writes beyond the register map must leave the setting alone.
    write_reg(REG_PAST_END, 16'hFFFF);
    write_reg(REG_IDX_TOP, 16'h1234);
    end_reg_writes();
    send_tick(16'sd5, 16'sd5);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle = 52;
        recv_idle = 20;
      end else if (seg == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      kind = (seg == 1 || seg == 9) ? SET_FULL_SCALE : (seg == 6) ? SET_ZERO : SET_RANDOM;
      pick_setting(kind);
      repeat (SEG_TICKS) send_random_tick();
      settle();
    end

    $display("%0d control ticks checked across %0d register settings and three idling mixes",
             checked, settings);
    $display("%0d of those ticks had the drive reversed by the jam guard", reversed);
    if (errors == 0 && pending == 0) begin
      $display("tb_velocity_pid_with_jam_reverse: done, clean");
    end else begin
      $display("tb_velocity_pid_with_jam_reverse: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/vpj_pkg.sv
rtl/vpj_cfg.sv
rtl/vpj_core.sv
rtl/velocity_pid_with_jam_reverse.sv
tb/vpj_checker.sv
tb/tb_velocity_pid_with_jam_reverse.sv
